@@ sv/lzop_pkg.sv @@
// Package: shared types and constants of the LZOP stream deframer.
package lzop_pkg;

    typedef enum logic [4:0] {
        P_MAGIC   = 5'd0,
        P_VERSION = 5'd1,
        P_LIBVER  = 5'd2,
        P_NEEDED  = 5'd3,
        P_METHOD  = 5'd4,
        P_LEVEL   = 5'd5,
        P_FLAGS   = 5'd6,
        P_MODE    = 5'd7,
        P_MTLO    = 5'd8,
        P_MTHI    = 5'd9,
        P_NAMELEN = 5'd10,
        P_NAME    = 5'd11,
        P_HSUM    = 5'd12,
        P_XLEN    = 5'd13,
        P_XDATA   = 5'd14,
        P_XSUM    = 5'd15,
        P_BEXP    = 5'd16,
        P_BPACK   = 5'd17,
        P_DADLER  = 5'd18,
        P_DCRC    = 5'd19,
        P_PADLER  = 5'd20,
        P_PCRC    = 5'd21,
        P_PAYLOAD = 5'd22
    } phase_t;

    localparam logic [2:0] K_PAYLOAD = 3'd0;
    localparam logic [2:0] K_EXPSIZE = 3'd1;
    localparam logic [2:0] K_PKSIZE  = 3'd2;
    localparam logic [2:0] K_DADLER  = 3'd3;
    localparam logic [2:0] K_DCRC    = 3'd4;
    localparam logic [2:0] K_SEND    = 3'd5;
    localparam logic [2:0] K_ERROR   = 3'd6;
    localparam logic [2:0] K_DONE    = 3'd7;

    localparam logic [3:0] E_NONE    = 4'd0;
    localparam logic [3:0] E_MAGIC   = 4'd1;
    localparam logic [3:0] E_VERSION = 4'd2;
    localparam logic [3:0] E_METHOD  = 4'd3;
    localparam logic [3:0] E_FLAGS   = 4'd4;
    localparam logic [3:0] E_HSUM    = 4'd5;
    localparam logic [3:0] E_EXTRA   = 4'd6;
    localparam logic [3:0] E_SIZES   = 4'd7;
    localparam logic [3:0] E_PSUM    = 4'd8;
    localparam logic [3:0] E_DSUM    = 4'd9;
    localparam logic [3:0] E_TRUNC   = 4'd10;

    localparam logic [1:0] REG_MAX_BLOCK = 2'd0;
    localparam logic [1:0] REG_MAX_EXTRA = 2'd1;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] value;
        logic        needs_expand;
        logic        block_end;
        logic [3:0]  error_code;
        logic        run_last;
    } result_t;

    // Work of one byte: up to two results.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } work_t;

    function automatic logic [7:0] magic_at(input logic [3:0] i);
        logic [7:0] m;
        case (i)
            4'd0:    m = 8'h89;
            4'd1:    m = 8'h4C;
            4'd2:    m = 8'h5A;
            4'd3:    m = 8'h4F;
            4'd4:    m = 8'h00;
            4'd5:    m = 8'h0D;
            4'd6:    m = 8'h0A;
            4'd7:    m = 8'h1A;
            4'd8:    m = 8'h0A;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] field_len(input phase_t p);
        logic [2:0] n;
        case (p)
            P_VERSION, P_LIBVER, P_NEEDED: n = 3'd2;
            P_METHOD, P_LEVEL, P_NAMELEN:  n = 3'd1;
            P_FLAGS, P_MODE, P_MTLO, P_MTHI, P_HSUM, P_XLEN, P_XSUM,
            P_BEXP, P_BPACK, P_DADLER, P_DCRC, P_PADLER, P_PCRC: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Byte-wise reflected CRC-32 step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return ~c;
    endfunction

    // Byte-wise Adler-32 step; each half stays below twice the modulus.
    function automatic logic [31:0] adler_byte(input logic [31:0] ad, input logic [7:0] b);
        logic [16:0] a;
        logic [16:0] s;
        a = {1'b0, ad[15:0]} + {9'd0, b};
        if (a >= 17'd65521) a = a - 17'd65521;
        s = {1'b0, ad[31:16]} + a;
        if (s >= 17'd65521) s = s - 17'd65521;
        return {s[15:0], a[15:0]};
    endfunction

endpackage

@@ sv/lzop_front.sv @@
// Front part: parses the container byte by byte and classifies each byte into results.
module lzop_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    input  logic                 final_byte,
    input  logic [26:0]          max_block_size,
    input  logic [24:0]          max_extra_size,
    output logic                 wvalid,
    output lzop_pkg::work_t      wdata,
    input  logic                 wfull
);

    lzop_pkg::phase_t phase_reg, phase_next;
    logic [26:0] cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] ver_reg, ver_next;
    logic [31:0] flags_reg, flags_next;
    logic [26:0] exp_reg, exp_next;
    logic [26:0] pk_reg, pk_next;
    logic [31:0] adl_reg, adl_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] eadl_reg, eadl_next;
    logic [31:0] ecrc_reg, ecrc_next;
    logic [31:0] nstr_reg, nstr_next;
    logic        err_reg, err_next;

    logic        take;
    logic        feed_en;
    logic        fld_done;
    logic [31:0] acc;
    logic [31:0] hsel;
    logic        v94;
    logic        comp;
    logic        comp_new;
    logic [31:0] adl_f;
    logic [31:0] crc_f;
    logic [2:0]  flen;
    lzop_pkg::result_t res0, res1;
    logic        n0, n1;

    assign in_stall = wfull;
    assign take     = in_valid && !wfull;

    function automatic lzop_pkg::result_t mk(input logic [2:0] k, input logic [7:0] b,
                                             input logic [31:0] v, input logic nx,
                                             input logic be, input logic [3:0] e);
        lzop_pkg::result_t r;
        r.kind = k; r.out_byte = b; r.value = v; r.needs_expand = nx;
        r.block_end = be; r.error_code = e; r.run_last = 1'b0;
        return r;
    endfunction

    // Pick the block phase that follows 'from' given the flags and compression.
    function automatic lzop_pkg::phase_t nxt_blk(input lzop_pkg::phase_t from,
                                                 input logic [31:0] fl, input logic cp);
        lzop_pkg::phase_t p;
        p = lzop_pkg::P_PAYLOAD;
        if (from == lzop_pkg::P_PCRC) p = lzop_pkg::P_PAYLOAD;
        else if (from != lzop_pkg::P_PADLER && cp && fl[2] == 1'b0 && fl[1])
            p = lzop_pkg::P_PADLER;
        else if (cp && fl[9]) p = lzop_pkg::P_PCRC;
        if (from == lzop_pkg::P_BPACK && fl[0]) p = lzop_pkg::P_DADLER;
        else if ((from == lzop_pkg::P_BPACK || from == lzop_pkg::P_DADLER) && fl[8])
            p = lzop_pkg::P_DCRC;
        else if ((from == lzop_pkg::P_BPACK || from == lzop_pkg::P_DADLER ||
                  from == lzop_pkg::P_DCRC) && cp && fl[1])
            p = lzop_pkg::P_PADLER;
        else if (from != lzop_pkg::P_PCRC && cp && fl[9])
            p = lzop_pkg::P_PCRC;
        else
            p = lzop_pkg::P_PAYLOAD;
        return p;
    endfunction

    always_comb
    begin
        phase_next = phase_reg; cnt_next = cnt_reg; shift_next = shift_reg;
        ver_next = ver_reg; flags_next = flags_reg; exp_next = exp_reg; pk_next = pk_reg;
        adl_next = adl_reg; crc_next = crc_reg; eadl_next = eadl_reg; ecrc_next = ecrc_reg;
        nstr_next = nstr_reg; err_next = err_reg;
        res0 = mk(lzop_pkg::K_PAYLOAD, 8'd0, 32'd0, 1'b0, 1'b0, lzop_pkg::E_NONE);
        res1 = res0; n0 = 1'b0; n1 = 1'b0;
        v94  = ver_reg >= 16'h0940;
        comp = pk_reg < exp_reg;
        flen = lzop_pkg::field_len(phase_reg);
        feed_en = (phase_reg >= lzop_pkg::P_VERSION && phase_reg <= lzop_pkg::P_NAME) ||
                  phase_reg == lzop_pkg::P_XLEN || phase_reg == lzop_pkg::P_XDATA ||
                  phase_reg == lzop_pkg::P_PAYLOAD;
        adl_f = feed_en ? lzop_pkg::adler_byte(adl_reg, in_byte) : adl_reg;
        crc_f = feed_en ? lzop_pkg::crc_byte(crc_reg, in_byte) : crc_reg;
        acc = {shift_reg[23:0], in_byte};
        fld_done = (cnt_reg + 27'd1) >= {24'd0, flen};
        hsel = flags_reg[12] ? crc_f : adl_f;
        comp_new = 1'b0;

        if (!err_reg) begin
            adl_next = adl_f; crc_next = crc_f;
            if (flen != 3'd0 && !fld_done) begin
                shift_next = acc; cnt_next = cnt_reg + 27'd1;
            end else begin
                if (flen == 3'd0) acc = shift_reg;
                hsel = flags_reg[12] ? crc_f : adl_f;
                case (phase_reg)
                    lzop_pkg::P_MAGIC:
                    begin
                        if (cnt_reg >= 27'd9 || in_byte != lzop_pkg::magic_at(cnt_reg[3:0])) begin
                            n0 = 1'b1; err_next = 1'b1;
                            res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                      lzop_pkg::E_MAGIC);
                        end else if (cnt_reg == 27'd8) begin
                            phase_next = lzop_pkg::P_VERSION; cnt_next = '0; shift_next = '0;
                            adl_next = 32'd1; crc_next = '0;
                        end else cnt_next = cnt_reg + 27'd1;
                    end
                    default:
                    begin
                        cnt_next = '0; shift_next = '0;
                        case (phase_reg)
                            lzop_pkg::P_VERSION:
                            begin
                                ver_next = acc[15:0]; phase_next = lzop_pkg::P_LIBVER;
                            end
                            lzop_pkg::P_LIBVER:
                            begin
                                if (ver_reg < 16'h0900 || ver_reg > 16'h1040) begin
                                    n0 = 1'b1; err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_VERSION);
                                end
                                phase_next = v94 ? lzop_pkg::P_NEEDED : lzop_pkg::P_METHOD;
                            end
                            lzop_pkg::P_NEEDED:
                            begin
                                if (acc[15:0] < 16'h0900 || acc[15:0] > 16'h1040) begin
                                    n0 = 1'b1; err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_VERSION);
                                end
                                phase_next = lzop_pkg::P_METHOD;
                            end
                            lzop_pkg::P_METHOD:
                            begin
                                if (acc[7:0] < 8'd1 || acc[7:0] > 8'd3) begin
                                    n0 = 1'b1; err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_METHOD);
                                end
                                phase_next = v94 ? lzop_pkg::P_LEVEL : lzop_pkg::P_FLAGS;
                            end
                            lzop_pkg::P_LEVEL: phase_next = lzop_pkg::P_FLAGS;
                            lzop_pkg::P_FLAGS:
                            begin
                                flags_next = acc;
                                if ((acc & ~32'hfff03fff) != 32'd0 || acc[11:10] != 2'd0) begin
                                    n0 = 1'b1; err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_FLAGS);
                                end
                                phase_next = lzop_pkg::P_MODE;
                            end
                            lzop_pkg::P_MODE: phase_next = lzop_pkg::P_MTLO;
                            lzop_pkg::P_MTLO:
                                phase_next = v94 ? lzop_pkg::P_MTHI : lzop_pkg::P_NAMELEN;
                            lzop_pkg::P_MTHI: phase_next = lzop_pkg::P_NAMELEN;
                            lzop_pkg::P_NAMELEN:
                            begin
                                if (acc[7:0] == 8'd0) phase_next = lzop_pkg::P_HSUM;
                                else begin
                                    phase_next = lzop_pkg::P_NAME;
                                    cnt_next = {19'd0, acc[7:0]};
                                end
                            end
                            lzop_pkg::P_NAME:
                            begin
                                if (cnt_reg <= 27'd1) phase_next = lzop_pkg::P_HSUM;
                                else cnt_next = cnt_reg - 27'd1;
                            end
                            lzop_pkg::P_HSUM:
                            begin
                                if (acc != hsel) begin
                                    n0 = 1'b1; err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_HSUM);
                                end
                                if (flags_reg[6]) begin
                                    phase_next = lzop_pkg::P_XLEN;
                                    adl_next = 32'd1; crc_next = '0;
                                end else phase_next = lzop_pkg::P_BEXP;
                            end
                            lzop_pkg::P_XLEN:
                            begin
                                if (acc > {7'd0, max_extra_size}) begin
                                    n0 = 1'b1; err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_EXTRA);
                                end
                                if (acc == 32'd0) phase_next = lzop_pkg::P_XSUM;
                                else begin
                                    phase_next = lzop_pkg::P_XDATA;
                                    cnt_next = acc[26:0];
                                end
                            end
                            lzop_pkg::P_XDATA:
                            begin
                                if (cnt_reg <= 27'd1) phase_next = lzop_pkg::P_XSUM;
                                else cnt_next = cnt_reg - 27'd1;
                            end
                            lzop_pkg::P_XSUM:
                            begin
                                if (acc != hsel) begin
                                    n0 = 1'b1; err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_EXTRA);
                                end
                                phase_next = lzop_pkg::P_BEXP;
                            end
                            lzop_pkg::P_BEXP:
                            begin
                                n0 = 1'b1;
                                if (acc == 32'd0) begin
                                    nstr_next = nstr_reg + 32'd1;
                                    phase_next = lzop_pkg::P_MAGIC;
                                    res0 = mk(lzop_pkg::K_SEND, 8'd0, nstr_reg + 32'd1, 1'b0,
                                              1'b0, lzop_pkg::E_NONE);
                                end else if (acc > {5'd0, max_block_size}) begin
                                    err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_SIZES);
                                end else begin
                                    exp_next = acc[26:0]; phase_next = lzop_pkg::P_BPACK;
                                    res0 = mk(lzop_pkg::K_EXPSIZE, 8'd0, acc, 1'b0, 1'b0,
                                              lzop_pkg::E_NONE);
                                end
                            end
                            lzop_pkg::P_BPACK:
                            begin
                                n0 = 1'b1;
                                if (acc == 32'd0 || acc > {5'd0, exp_reg}) begin
                                    err_next = 1'b1;
                                    res0 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                              lzop_pkg::E_SIZES);
                                end else begin
                                    pk_next = acc[26:0];
                                    comp_new = acc[26:0] < exp_reg;
                                    phase_next = nxt_blk(lzop_pkg::P_BPACK, flags_reg, comp_new);
                                    res0 = mk(lzop_pkg::K_PKSIZE, 8'd0, acc, comp_new, 1'b0,
                                              lzop_pkg::E_NONE);
                                end
                            end
                            lzop_pkg::P_DADLER:
                            begin
                                n0 = 1'b1; eadl_next = acc;
                                phase_next = nxt_blk(lzop_pkg::P_DADLER, flags_reg, comp);
                                res0 = mk(lzop_pkg::K_DADLER, 8'd0, acc, comp, 1'b0,
                                          lzop_pkg::E_NONE);
                            end
                            lzop_pkg::P_DCRC:
                            begin
                                n0 = 1'b1; ecrc_next = acc;
                                phase_next = nxt_blk(lzop_pkg::P_DCRC, flags_reg, comp);
                                res0 = mk(lzop_pkg::K_DCRC, 8'd0, acc, comp, 1'b0,
                                          lzop_pkg::E_NONE);
                            end
                            lzop_pkg::P_PADLER:
                            begin
                                eadl_next = acc;
                                phase_next = nxt_blk(lzop_pkg::P_PADLER, flags_reg, comp);
                            end
                            lzop_pkg::P_PCRC:
                            begin
                                ecrc_next = acc;
                                phase_next = lzop_pkg::P_PAYLOAD;
                            end
                            lzop_pkg::P_PAYLOAD:
                            begin
                                n0 = 1'b1;
                                if (cnt_reg > 27'd1) begin
                                    cnt_next = cnt_reg - 27'd1;
                                    res0 = mk(lzop_pkg::K_PAYLOAD, in_byte, 32'd0, comp, 1'b0,
                                              lzop_pkg::E_NONE);
                                end else begin
                                    res0 = mk(lzop_pkg::K_PAYLOAD, in_byte, 32'd0, comp, 1'b1,
                                              lzop_pkg::E_NONE);
                                    phase_next = lzop_pkg::P_BEXP;
                                    if (comp ? ((flags_reg[1] && adl_f != eadl_reg) ||
                                                (flags_reg[9] && crc_f != ecrc_reg))
                                             : ((flags_reg[0] && adl_f != eadl_reg) ||
                                                (flags_reg[8] && crc_f != ecrc_reg))) begin
                                        n1 = 1'b1; err_next = 1'b1;
                                        res1 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0,
                                                  comp ? lzop_pkg::E_PSUM : lzop_pkg::E_DSUM);
                                    end
                                end
                            end
                            default: phase_next = lzop_pkg::P_MAGIC;
                        endcase
                        // Entering payload: load the packed length and restart sums.
                        if (phase_next == lzop_pkg::P_PAYLOAD &&
                            phase_reg != lzop_pkg::P_PAYLOAD) begin
                            cnt_next = (phase_reg == lzop_pkg::P_BPACK) ? acc[26:0] : pk_reg;
                            adl_next = 32'd1; crc_next = '0;
                        end
                    end
                endcase
            end
        end

        // End of region: finish and return to reset state.
        if (final_byte) begin
            if (!err_next) begin
                if (phase_next == lzop_pkg::P_MAGIC && cnt_next == 27'd0 && nstr_next != 32'd0)
                    res1 = mk(lzop_pkg::K_DONE, 8'd0, nstr_next, 1'b0, 1'b0, lzop_pkg::E_NONE);
                else
                    res1 = mk(lzop_pkg::K_ERROR, 8'd0, 32'd0, 1'b0, 1'b0, lzop_pkg::E_TRUNC);
                n1 = 1'b1;
            end
            phase_next = lzop_pkg::P_MAGIC; cnt_next = '0; shift_next = '0;
            ver_next = '0; flags_next = '0; exp_next = '0; pk_next = '0;
            adl_next = 32'd1; crc_next = '0; eadl_next = '0; ecrc_next = '0;
            nstr_next = '0; err_next = 1'b0;
        end

        // Pack results so the first slot is always filled.
        wdata.two = n0 && n1;
        if (n0) begin
            wdata.r0 = res0; wdata.r1 = res1;
        end else begin
            wdata.r0 = res1; wdata.r1 = res1;
        end
        if (n0 && n1) wdata.r1.run_last = 1'b1;
        else wdata.r0.run_last = 1'b1;
        wvalid = take && (n0 || n1);
    end

    // Hold the parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= lzop_pkg::P_MAGIC; cnt_reg <= '0; shift_reg <= '0;
            ver_reg <= '0; flags_reg <= '0; exp_reg <= '0; pk_reg <= '0;
            adl_reg <= 32'd1; crc_reg <= '0; eadl_reg <= '0; ecrc_reg <= '0;
            nstr_reg <= '0; err_reg <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; shift_reg <= shift_next;
            ver_reg <= ver_next; flags_reg <= flags_next; exp_reg <= exp_next;
            pk_reg <= pk_next; adl_reg <= adl_next; crc_reg <= crc_next;
            eadl_reg <= eadl_next; ecrc_reg <= ecrc_next; nstr_reg <= nstr_next;
            err_reg <= err_next;
        end
    end

endmodule

@@ sv/lzop_back.sv @@
// Back part: queue of classified bytes and serializer of their results.
module lzop_back #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wvalid,
    input  lzop_pkg::work_t      wdata,
    output logic                 wfull,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lzop_pkg::result_t    res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lzop_pkg::work_t q_mem [DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   n_reg, n_next;
    logic          sub_reg, sub_next;
    logic          pop, push, fin;
    lzop_pkg::work_t head;

    assign head      = q_mem[rp_reg];
    assign out_valid = n_reg != '0;
    assign res       = sub_reg ? head.r1 : head.r0;
    assign wfull     = n_reg == (AW+1)'(DEPTH);
    assign push      = wvalid && !wfull;
    assign fin       = out_valid && !out_stall;
    assign pop       = fin && (sub_reg || !head.two);

    // Advance pointers and the count.
    always_comb
    begin
        wp_next  = push ? ((wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = pop ? ((rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        n_next   = n_reg + (AW+1)'(push) - (AW+1)'(pop);
        sub_next = fin ? !pop : sub_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; n_reg <= '0; sub_reg <= 1'b0;
        end else begin
            wp_reg <= wp_next; rp_reg <= rp_next; n_reg <= n_next; sub_reg <= sub_next;
        end
    end

    // Store entries.
    always_ff @(posedge clk)
    begin
        if (push) q_mem[wp_reg] <= wdata;
    end

endmodule

@@ sv/lzop_stream_deframer_core.sv @@
// Top level: LZOP stream deframer with configuration registers.
//
// Input channel: in_valid/in_stall carry one source byte (in_byte) and the
// final_byte mark per transfer. Output channel: out_valid/out_stall carry one
// result (kind, out_byte, value, needs_expand, block_end, error_code, run_last).
// A byte gives zero, one or two results. One byte is taken per cycle while
// in_stall is low; the parser settles a byte's results combinationally and
// writes them into the queue. A byte with two results gives them out in turn.
// A four-entry queue separates the parser from the output; when the receiver
// stalls the queue fills and then in_stall rises. Reset clears the parse
// state and the queue and loads the size limits with their defaults.
// Registers over APB: 0 max_block_size, 1 max_extra_size; write only while
// idle.
module lzop_stream_deframer_core #(
    parameter int QDEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic [31:0] value,
    output logic        needs_expand,
    output logic        block_end,
    output logic [3:0]  error_code,
    output logic        run_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [26:0] mbs_reg;
    logic [24:0] mes_reg;
    logic        wvalid, wfull;
    lzop_pkg::work_t   wdata;
    lzop_pkg::result_t res;

    assign pready = 1'b1;

    // Write configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mbs_reg <= 27'd67108864;
            mes_reg <= 25'd16777216;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == lzop_pkg::REG_MAX_EXTRA[0]) mes_reg <= pwdata[24:0];
            else                                         mbs_reg <= pwdata[26:0];
        end
    end

    // Read back.
    always_comb
    begin
        prdata = 32'd0;
        case ({1'b0, paddr[2]})
            lzop_pkg::REG_MAX_BLOCK: prdata = {5'd0, mbs_reg};
            lzop_pkg::REG_MAX_EXTRA: prdata = {7'd0, mes_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    lzop_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_byte(in_byte), .final_byte(final_byte),
        .max_block_size(mbs_reg), .max_extra_size(mes_reg),
        .wvalid(wvalid), .wdata(wdata), .wfull(wfull)
    );

    lzop_back #(.DEPTH(QDEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .wvalid(wvalid), .wdata(wdata), .wfull(wfull),
        .out_valid(out_valid), .out_stall(out_stall), .res(res)
    );

    assign kind         = res.kind;
    assign out_byte     = res.out_byte;
    assign value        = res.value;
    assign needs_expand = res.needs_expand;
    assign block_end    = res.block_end;
    assign error_code   = res.error_code;
    assign run_last     = res.run_last;

endmodule
